// ===== rtl/core/jddm_pkg.sv =====
// ----------------------------------------------------------------------------
// jddm_pkg
// Shared types and constants of the joystick differential drive mixer:
// sequencer states, divider handshake structs, register indexes and widths.
// ----------------------------------------------------------------------------
package jddm_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_X_AXIS = 2'd0;
	localparam logic [1:0] REG_Y_AXIS = 2'd1;
	localparam logic [1:0] REG_TOGGLE = 2'd2;

	// Register reset values.
	localparam logic [7:0] X_AXIS_RESET = 8'd2;
	localparam logic [7:0] Y_AXIS_RESET = 8'd3;
	localparam logic [7:0] TOGGLE_RESET = 8'd16;

	// Datapath widths. Magnitudes reach 32768 and fit 16 bits; the
	// sum of two magnitudes reaches 65536 and needs 17 bits.
	localparam int MAG_W    = 17;
	localparam int SCALED_W = 23;                 // 32768 * 255 fits 23 bits
	localparam int PROD_W   = MAG_W + SCALED_W;   // shared multiplier result
	localparam int SHIFT    = 15;                 // divide by 32768
	localparam int QUOT_W   = 8;                  // drive magnitude 0..255
	localparam int DRIVE_W  = 9;
	localparam int DIV_STEPS = QUOT_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [SCALED_W-1:0] DRIVE_SCALE = SCALED_W'(255);

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_S,
		ST_MUL_T,
		ST_DIV,
		ST_OUT
	} state_t;

	// Divider control and status.
	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/core/jddm_div.sv =====
// ----------------------------------------------------------------------------
// jddm_div
// Restoring divider with one shared compare-and-subtract stage. It resolves
// one quotient bit per cycle over a fixed number of steps. The caller
// guarantees that the upper dividend part is already below the divisor.
// ----------------------------------------------------------------------------
module jddm_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  jddm_pkg::div_ctrl_t              ctrl,
	input  logic [jddm_pkg::MAG_W-1:0]       rem_init,
	input  logic [jddm_pkg::QUOT_W-1:0]      low_init,
	input  logic [jddm_pkg::MAG_W-1:0]       divisor,
	output jddm_pkg::div_stat_t              stat,
	output logic [jddm_pkg::QUOT_W-1:0]      quotient
);

	logic                             busy_q;
	logic [jddm_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [jddm_pkg::MAG_W-1:0]       rem_q;
	logic [jddm_pkg::QUOT_W-1:0]      low_q;
	logic [jddm_pkg::MAG_W-1:0]       div_q;
	logic [jddm_pkg::MAG_W:0]         trial;
	logic [jddm_pkg::MAG_W:0]         diff;
	logic                             fits;
	logic                             last;

	// Shift the next dividend bit into the partial remainder and compare.
	assign trial = {rem_q, low_q[jddm_pkg::QUOT_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};
	assign last  = cnt_q == jddm_pkg::DIV_CNT_W'(jddm_pkg::DIV_STEPS - 1);

	assign stat.busy = busy_q;
	assign stat.done = busy_q && last;
	assign quotient  = low_q;

	// Step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and dividend/quotient shift register.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= rem_init;
			low_q <= low_init;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[jddm_pkg::MAG_W-1:0] : trial[jddm_pkg::MAG_W-1:0];
			low_q <= {low_q[jddm_pkg::QUOT_W-2:0], fits};
		end
	end

endmodule

// ===== rtl/core/joystick_differential_drive_mixer.sv =====
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer
// Arcade-drive mixer: joystick axis and button items in, left/right drive
// commands out, computed with one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
// An axis item on the turn or throttle axis stores the stick position and,
// while drive is enabled, yields one left/right pair: the prepare state forms
// the magnitudes, two passes go through the shared multiplier, the divider
// resolves one quotient bit per cycle, and the out state loads the output
// register once it is free. The next item is taken only after such an item
// has left the out state. Items that give no result are taken without leaving
// the idle state; a toggle release that turns drive off yields a zero pair
// through the out state, and a stick back at the center yields a zero pair
// through the prepare and out states. The input is not ready while an item is
// being worked on or while a finished pair waits for a full output register.
module joystick_differential_drive_mixer (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration writes.
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [7:0]                          cfg_wdata,
	// Input items.
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                is_axis,
	input  logic                                is_button,
	input  logic                                is_init,
	input  logic [7:0]                          event_number,
	input  logic signed [15:0]                  event_value,
	// Result items.
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [jddm_pkg::DRIVE_W-1:0] left_drive,
	output logic signed [jddm_pkg::DRIVE_W-1:0] right_drive
);

	localparam int MW = jddm_pkg::MAG_W;
	localparam int DW = jddm_pkg::DRIVE_W;

	jddm_pkg::state_t state_q, state_d;

	logic [7:0]  x_axis_q, y_axis_q, toggle_q;
	logic [15:0] x_pos_q, y_pos_q;
	logic        enabled_q;

	logic        accept, x_hit, y_hit, toggle_hit;

	logic [MW-1:0] x_ext, y_ext, ax, ay, mag, dif;
	logic          ay_ge;

	logic [MW-1:0]                 m_q, d_q, sum_q;
	logic                          ay_ge_q, xneg_q, yneg_q, zero_q;
	logic [jddm_pkg::SCALED_W-1:0] p_q;
	logic [jddm_pkg::QUOT_W-1:0]   s_q;

	logic [MW-1:0]                 mul_a;
	logic [jddm_pkg::SCALED_W-1:0] mul_b;
	logic [jddm_pkg::PROD_W-1:0]   prod;

	jddm_pkg::div_ctrl_t         div_ctrl;
	jddm_pkg::div_stat_t         div_stat;
	logic [jddm_pkg::QUOT_W-1:0] quot;

	logic          load;
	logic [DW-1:0] s9, t9, ns9, nt9, left_d, right_d;
	logic          out_valid_q;
	logic [DW-1:0] left_q, right_q;

	// Item decode.
	assign in_ready   = state_q == jddm_pkg::ST_IDLE;
	assign accept     = in_valid && in_ready;
	assign x_hit      = is_axis && event_number == x_axis_q;
	assign y_hit      = is_axis && !x_hit && event_number == y_axis_q;
	assign toggle_hit = !is_axis && is_button && !is_init && event_number == toggle_q
		&& event_value == 16'sd0;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_axis_q <= jddm_pkg::X_AXIS_RESET;
			y_axis_q <= jddm_pkg::Y_AXIS_RESET;
			toggle_q <= jddm_pkg::TOGGLE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				jddm_pkg::REG_X_AXIS: x_axis_q <= cfg_wdata;
				jddm_pkg::REG_Y_AXIS: y_axis_q <= cfg_wdata;
				jddm_pkg::REG_TOGGLE: toggle_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stick positions and drive enable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_pos_q   <= '0;
			y_pos_q   <= '0;
			enabled_q <= 1'b0;
		end else if (accept) begin
			if (x_hit) begin
				x_pos_q <= event_value;
			end
			if (y_hit) begin
				y_pos_q <= event_value;
			end
			if (toggle_hit) begin
				enabled_q <= !enabled_q;
			end
		end
	end

	// Magnitudes of the stored positions.
	assign x_ext = {x_pos_q[15], x_pos_q};
	assign y_ext = {y_pos_q[15], y_pos_q};
	assign ax    = x_ext[MW-1] ? (~x_ext + MW'(1)) : x_ext;
	assign ay    = y_ext[MW-1] ? (~y_ext + MW'(1)) : y_ext;
	assign ay_ge = ay >= ax;
	assign mag   = ay_ge ? ay : ax;
	assign dif   = ay_ge ? (ay - ax) : (ax - ay);

	// Shared multiplier: first M * 255, then |ay - ax| * M * 255.
	assign mul_a = (state_q == jddm_pkg::ST_MUL_S) ? m_q : d_q;
	assign mul_b = (state_q == jddm_pkg::ST_MUL_S) ? jddm_pkg::DRIVE_SCALE : p_q;
	assign prod  = jddm_pkg::PROD_W'(mul_a) * jddm_pkg::PROD_W'(mul_b);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jddm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and divider start.
	always_comb begin
		state_d        = state_q;
		div_ctrl.start = 1'b0;
		case (state_q)
			jddm_pkg::ST_IDLE: begin
				if (accept && enabled_q && (x_hit || y_hit)) begin
					state_d = jddm_pkg::ST_PREP;
				end else if (accept && enabled_q && toggle_hit) begin
					state_d = jddm_pkg::ST_OUT;
				end
			end
			jddm_pkg::ST_PREP: begin
				state_d = (ax == '0 && ay == '0) ? jddm_pkg::ST_OUT : jddm_pkg::ST_MUL_S;
			end
			jddm_pkg::ST_MUL_S: begin
				state_d = jddm_pkg::ST_MUL_T;
			end
			jddm_pkg::ST_MUL_T: begin
				div_ctrl.start = 1'b1;
				state_d        = jddm_pkg::ST_DIV;
			end
			jddm_pkg::ST_DIV: begin
				if (div_stat.done) begin
					state_d = jddm_pkg::ST_OUT;
				end
			end
			jddm_pkg::ST_OUT: begin
				if (load) begin
					state_d = jddm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = jddm_pkg::ST_IDLE;
			end
		endcase
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		if (state_q == jddm_pkg::ST_IDLE && accept) begin
			zero_q <= 1'b1;
		end
		if (state_q == jddm_pkg::ST_PREP) begin
			m_q     <= mag;
			d_q     <= dif;
			sum_q   <= ay + ax;
			ay_ge_q <= ay_ge;
			xneg_q  <= x_pos_q[15];
			yneg_q  <= y_pos_q[15];
			zero_q  <= ax == '0 && ay == '0;
		end
		if (state_q == jddm_pkg::ST_MUL_S) begin
			p_q <= prod[jddm_pkg::SCALED_W-1:0];
			s_q <= prod[jddm_pkg::SHIFT +: jddm_pkg::QUOT_W];
		end
	end

	// Divide (|ay - ax| * M * 255 / 32768) by (ay + ax); the quotient fits 8 bits,
	// so the bits above the low quotient byte already sit below the divisor.
	jddm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.rem_init (MW'(prod[jddm_pkg::PROD_W-2:jddm_pkg::SHIFT + jddm_pkg::QUOT_W])),
		.low_init (prod[jddm_pkg::SHIFT +: jddm_pkg::QUOT_W]),
		.divisor  (sum_q),
		.stat     (div_stat),
		.quotient (quot)
	);

	// Quadrant mapping of the two magnitudes onto the motor sides.
	assign s9  = {1'b0, s_q};
	assign t9  = ay_ge_q ? {1'b0, quot} : -{1'b0, quot};
	assign ns9 = -s9;
	assign nt9 = -t9;

	always_comb begin
		left_d  = '0;
		right_d = '0;
		if (!zero_q) begin
			case ({xneg_q, yneg_q})
				2'b00: begin
					left_d  = ns9;
					right_d = nt9;
				end
				2'b10: begin
					left_d  = nt9;
					right_d = ns9;
				end
				2'b11: begin
					left_d  = s9;
					right_d = t9;
				end
				default: begin
					left_d  = t9;
					right_d = s9;
				end
			endcase
		end
	end

	// Output register.
	assign load = state_q == jddm_pkg::ST_OUT && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_q  <= left_d;
			right_q <= right_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign left_drive  = left_q;
	assign right_drive = right_q;

	// The divider only finishes while the sequencer waits for it.
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == jddm_pkg::ST_DIV)
		else $error("divider finished outside the divide state");

	// The divider is running for the whole divide state.
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jddm_pkg::ST_DIV |-> div_stat.busy)
		else $error("divide state without a running divider");

	// The other side's drive never exceeds the main drive magnitude.
	a_turn_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == jddm_pkg::ST_OUT && !zero_q) |-> quot <= s_q)
		else $error("turn magnitude above drive magnitude");

	// Drive values stay within -255..255.
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_drive != 9'h100 && right_drive != 9'h100))
		else $error("drive value out of range");

endmodule
